### src/irp_pkg.sv
// ----------------------------------------------------------------------------
// irp_pkg
// shared types, constants and codes of the irprop+ step update block
// ----------------------------------------------------------------------------
package irp_pkg;

    localparam int MAX_PARAMS = 1024;
    localparam int IDX_W      = $clog2(MAX_PARAMS);
    localparam int CNT_W      = $clog2(MAX_PARAMS + 1);
    localparam int SIZE_W     = 30;
    localparam int STEP_W     = 32;
    localparam int FAC_W      = 16;
    localparam int FRAC_W     = 14;
    localparam int QDEPTH     = 2;

    // configuration register indexes
    localparam logic [2:0] CFG_PARAM_COUNT   = 3'd0;
    localparam logic [2:0] CFG_DELTA_INITIAL = 3'd1;
    localparam logic [2:0] CFG_DELTA_FLOOR   = 3'd2;
    localparam logic [2:0] CFG_DELTA_CEILING = 3'd3;
    localparam logic [2:0] CFG_GROW_FACTOR   = 3'd4;
    localparam logic [2:0] CFG_SHRINK_FACTOR = 3'd5;

    // gradient sign codes
    localparam logic [1:0] SIGN_ZERO = 2'd0;
    localparam logic [1:0] SIGN_POS  = 2'd1;
    localparam logic [1:0] SIGN_NEG  = 2'd3;

    typedef enum logic [1:0] {
        BR_GROW   = 2'd0,
        BR_REVERT = 2'd1,
        BR_HOLD   = 2'd2,
        BR_KEEP   = 2'd3
    } branch_t;

    typedef struct packed {
        logic [CNT_W-1:0]  param_count;
        logic [SIZE_W-1:0] delta_initial;
        logic [SIZE_W-1:0] delta_floor;
        logic [SIZE_W-1:0] delta_ceiling;
        logic [FAC_W-1:0]  grow_factor;
        logic [FRAC_W-1:0] shrink_factor;
    } cfg_t;

    // per-coordinate memory line
    typedef struct packed {
        logic [STEP_W-1:0] step;
        logic [1:0]        sign;
        logic [SIZE_W-1:0] size;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    // classified item handed from front to back
    typedef struct packed {
        logic [1:0]       gsign;
        logic [IDX_W-1:0] idx;
        logic             last;
        logic             started;
        logic             worse;
        entry_t           entry;
    } item_t;

endpackage

### src/irp_ram.sv
// ----------------------------------------------------------------------------
// irp_ram
// generic single-write, single-read memory with registered read data
// ----------------------------------------------------------------------------
module irp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end
endmodule

### src/irp_front.sv
// ----------------------------------------------------------------------------
// irp_front
// accepts gradients, tracks coordinate/iteration, issues the memory read
// ----------------------------------------------------------------------------
module irp_front (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  irp_pkg::cfg_t                cfg,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [63:0]                  s_tdata,
    output logic                         rd_en,
    output logic [irp_pkg::IDX_W-1:0]    rd_addr,
    input  irp_pkg::entry_t              rd_entry,
    input  logic [1:0]                   q_level,
    output logic                         push,
    output irp_pkg::item_t               push_item
);
    import irp_pkg::*;

    logic [IDX_W-1:0]  coord_reg;
    logic              started_reg;
    logic              worse_reg;
    logic signed [31:0] prev_obj_reg;
    logic              s1_valid_reg;
    item_t             s1_item_reg;

    logic              accept;
    logic [CNT_W-1:0]  count_eff;
    logic              last;
    logic              worse_now;
    logic signed [31:0] grad;
    logic signed [31:0] obj;
    logic [1:0]        gsign;

    assign grad = s_tdata[31:0];
    assign obj  = s_tdata[63:32];

    always_comb begin
        if (cfg.param_count == '0) begin
            count_eff = CNT_W'(1);
        end else if (cfg.param_count > CNT_W'(MAX_PARAMS)) begin
            count_eff = CNT_W'(MAX_PARAMS);
        end else begin
            count_eff = cfg.param_count;
        end
    end

    assign last      = ({1'b0, coord_reg} + CNT_W'(1)) >= count_eff;
    assign worse_now = (coord_reg == '0) ? (started_reg && (obj > prev_obj_reg)) : worse_reg;
    assign gsign     = (grad > 0) ? SIGN_POS : ((grad < 0) ? SIGN_NEG : SIGN_ZERO);

    // room for the item in the read stage plus the new one
    assign s_tready = ({1'b0, q_level} + {2'b0, s1_valid_reg}) < 3'(QDEPTH);
    assign accept   = s_tvalid && s_tready;
    assign rd_en    = accept;
    assign rd_addr  = coord_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coord_reg    <= '0;
            started_reg  <= 1'b0;
            worse_reg    <= 1'b0;
            s1_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= accept;
            if (accept) begin
                worse_reg <= worse_now;
                if (last) begin
                    coord_reg   <= '0;
                    started_reg <= 1'b1;
                end else begin
                    coord_reg <= coord_reg + IDX_W'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            if (coord_reg == '0) begin
                prev_obj_reg <= obj;
            end
            s1_item_reg.gsign   <= gsign;
            s1_item_reg.idx     <= coord_reg;
            s1_item_reg.last    <= last;
            s1_item_reg.started <= started_reg;
            s1_item_reg.worse   <= worse_now;
            s1_item_reg.entry   <= '0;
        end
    end

    assign push = s1_valid_reg;
    always_comb begin
        push_item       = s1_item_reg;
        push_item.entry = rd_entry;
    end
endmodule

### src/irp_queue.sv
// ----------------------------------------------------------------------------
// irp_queue
// two-entry queue between front and back
// ----------------------------------------------------------------------------
module irp_queue (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  irp_pkg::item_t  push_item,
    input  logic            pop,
    output logic            not_empty,
    output irp_pkg::item_t  head,
    output logic [1:0]      level_after_pop
);
    import irp_pkg::*;

    item_t      slot_reg [QDEPTH];
    logic       wptr_reg;
    logic       rptr_reg;
    logic [1:0] cnt_reg;

    assign not_empty       = cnt_reg != '0;
    assign head            = slot_reg[rptr_reg];
    assign level_after_pop = cnt_reg - {1'b0, pop};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            if (push) begin
                wptr_reg <= ~wptr_reg;
            end
            if (pop) begin
                rptr_reg <= ~rptr_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wptr_reg] <= push_item;
        end
    end
endmodule

### src/irp_back.sv
// ----------------------------------------------------------------------------
// irp_back
// picks the branch, resizes, writes the line back and holds the result
// ----------------------------------------------------------------------------
module irp_back (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  irp_pkg::cfg_t             cfg,
    input  logic                      q_not_empty,
    input  irp_pkg::item_t            head,
    output logic                      pop,
    output logic                      wr_en,
    output logic [irp_pkg::IDX_W-1:0] wr_addr,
    output irp_pkg::entry_t           wr_entry,
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [47:0]               m_tdata,
    output logic                      m_tlast,
    output logic [1:0]                m_tuser
);
    import irp_pkg::*;

    localparam int HIST = 4;
    localparam int PROD_W = SIZE_W + FAC_W;

    // recent writes, newest in slot 0, cover reads issued before them
    logic             hv_reg  [HIST];
    logic [IDX_W-1:0] hidx_reg[HIST];
    entry_t           hent_reg[HIST];

    logic              valid_reg;
    logic [STEP_W-1:0] step_reg;
    logic [IDX_W-1:0]  idx_reg;
    logic              last_reg;
    branch_t           branch_reg;

    entry_t            cur;
    logic [SIZE_W-1:0] size;
    logic [1:0]        psign;
    logic              same;
    logic              flip;
    logic [FAC_W-1:0]  factor;
    logic [PROD_W-1:0] prod;
    logic [31:0]       scaled;
    logic [SIZE_W-1:0] new_size;
    logic [STEP_W-1:0] step;
    logic [STEP_W-1:0] prev_step;
    logic [1:0]        new_sign;
    branch_t           branch;

    assign pop = q_not_empty && (!valid_reg || m_tready);

    always_comb begin
        cur = head.entry;
        for (int k = HIST - 1; k >= 0; k--) begin
            if (hv_reg[k] && hidx_reg[k] == head.idx) begin
                cur = hent_reg[k];
            end
        end
    end

    assign size   = head.started ? cur.size : cfg.delta_initial;
    assign psign  = head.started ? cur.sign : SIGN_ZERO;
    assign same   = (psign != SIGN_ZERO) && (head.gsign != SIGN_ZERO) && (psign == head.gsign);
    assign flip   = (psign != SIGN_ZERO) && (head.gsign != SIGN_ZERO) && (psign != head.gsign);
    assign factor = same ? cfg.grow_factor : {2'b00, cfg.shrink_factor};
    assign prod   = PROD_W'(size) * PROD_W'(factor);
    assign scaled = prod[PROD_W-1:FRAC_W];
    assign prev_step = head.started ? cur.step : '0;

    always_comb begin
        new_size = size;
        step     = '0;
        new_sign = head.gsign;
        branch   = BR_KEEP;
        if (same) begin
            new_size = (scaled < {2'b00, cfg.delta_ceiling}) ? scaled[SIZE_W-1:0]
                                                             : cfg.delta_ceiling;
            branch   = BR_GROW;
        end else if (flip) begin
            new_size = (scaled > {2'b00, cfg.delta_floor}) ? scaled[SIZE_W-1:0]
                                                           : cfg.delta_floor;
            new_sign = SIGN_ZERO;
            if (head.worse) begin
                branch = BR_REVERT;
                // negating the most negative step saturates
                step   = (prev_step == 32'h8000_0000) ? 32'h7FFF_FFFF : (~prev_step + 32'd1);
            end else begin
                branch = BR_HOLD;
            end
        end
        if (!flip) begin
            if (head.gsign == SIGN_POS) begin
                step = ~{2'b00, new_size} + 32'd1;
            end else if (head.gsign == SIGN_NEG) begin
                step = {2'b00, new_size};
            end else begin
                step = '0;
            end
        end
    end

    assign wr_en         = pop;
    assign wr_addr       = head.idx;
    assign wr_entry.size = new_size;
    assign wr_entry.sign = new_sign;
    assign wr_entry.step = step;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            for (int k = 0; k < HIST; k++) begin
                hv_reg[k] <= 1'b0;
            end
        end else begin
            if (pop) begin
                valid_reg <= 1'b1;
                hv_reg[0] <= 1'b1;
                for (int k = 1; k < HIST; k++) begin
                    hv_reg[k] <= hv_reg[k-1];
                end
            end else if (m_tready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            step_reg    <= step;
            idx_reg     <= head.idx;
            last_reg    <= head.last;
            branch_reg  <= branch;
            hidx_reg[0] <= head.idx;
            hent_reg[0] <= wr_entry;
            for (int k = 1; k < HIST; k++) begin
                hidx_reg[k] <= hidx_reg[k-1];
                hent_reg[k] <= hent_reg[k-1];
            end
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {6'b0, idx_reg, step_reg};
    assign m_tlast  = last_reg;
    assign m_tuser  = branch_reg;
endmodule

### src/irprop_plus_step_update.sv
// ----------------------------------------------------------------------------
// irprop_plus_step_update
// irprop+ step generator, one coordinate gradient per beat
// ----------------------------------------------------------------------------
// One result beat per input beat, in order. A beat is taken every cycle when
// the result side keeps up; each input beat reaches its result through the
// memory read, queue and result register. The rate is set by the single
// read and single write port of the per-coordinate memory, one line per
// coordinate. The front counts coordinates, makes the objective test on
// coordinate 0 and starts the line read; the back picks the branch, resizes
// with one multiplier, writes the line back and holds the result. Writes still
// in flight for the same coordinate (short iterations) are forwarded from a
// short history of recent writes. Memory contents are undefined until the
// first iteration has passed; no clearing pass is needed.
module irprop_plus_step_update (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [29:0] cfg_wdata,
    // input beats
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // gradient [31:0], objective [63:32]
    // result beats
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // step_value [31:0], coord_index [41:32], zero pad
    output logic        m_tlast,   // iteration_end
    output logic [1:0]  m_tuser    // branch_taken
);
    import irp_pkg::*;

    cfg_t             cfg_reg;

    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic [ENTRY_W-1:0] rd_data;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    entry_t           wr_entry;
    logic             push;
    item_t            push_item;
    logic             pop;
    logic             q_not_empty;
    item_t            head;
    logic [1:0]       q_level;

    // configuration registers; the user must write them only while idle, the block does not enforce it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.param_count   <= CNT_W'(MAX_PARAMS);
            cfg_reg.delta_initial <= SIZE_W'(1677722);
            cfg_reg.delta_floor   <= SIZE_W'(17);
            cfg_reg.delta_ceiling <= SIZE_W'(838860800);
            cfg_reg.grow_factor   <= FAC_W'(19661);
            cfg_reg.shrink_factor <= FRAC_W'(8192);
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_PARAM_COUNT:   cfg_reg.param_count   <= cfg_wdata[CNT_W-1:0];
                CFG_DELTA_INITIAL: cfg_reg.delta_initial <= cfg_wdata;
                CFG_DELTA_FLOOR:   cfg_reg.delta_floor   <= cfg_wdata;
                CFG_DELTA_CEILING: cfg_reg.delta_ceiling <= cfg_wdata;
                CFG_GROW_FACTOR:   cfg_reg.grow_factor   <= cfg_wdata[FAC_W-1:0];
                CFG_SHRINK_FACTOR: cfg_reg.shrink_factor <= cfg_wdata[FRAC_W-1:0];
                default: ;
            endcase
        end
    end

    irp_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .rd_entry  (entry_t'(rd_data)),
        .q_level   (q_level),
        .push      (push),
        .push_item (push_item)
    );

    // per-coordinate lines: size, sign, previous step
    irp_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_PARAMS)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_entry),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    irp_queue u_queue (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .push            (push),
        .push_item       (push_item),
        .pop             (pop),
        .not_empty       (q_not_empty),
        .head            (head),
        .level_after_pop (q_level)
    );

    irp_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg_reg),
        .q_not_empty (q_not_empty),
        .head        (head),
        .pop         (pop),
        .wr_en       (wr_en),
        .wr_addr     (wr_addr),
        .wr_entry    (wr_entry),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .m_tuser     (m_tuser)
    );
endmodule

### src/irp_checker.sv
// ----------------------------------------------------------------------------
// irp_checker
// port-level checks of the irprop+ step update block
// ----------------------------------------------------------------------------
module irp_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [47:0] m_tdata,
    input logic        m_tlast,
    input logic [1:0]  m_tuser
);
    import irp_pkg::*;

    // a stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                  && $stable(m_tlast))
        else $error("result changed while stalled");

    // a held flip gives no step
    a_hold_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == BR_HOLD |-> m_tdata[31:0] == 32'd0)
        else $error("hold branch with nonzero step");

    // growth always moves against the gradient, never zero
    a_grow_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == BR_GROW |-> m_tdata[31:0] != 32'd0)
        else $error("grow branch with zero step");

    // pad bits stay zero
    a_pad: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[47:42] == 6'd0)
        else $error("pad bits set");
endmodule

bind irprop_plus_step_update irp_checker u_irp_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);

### verif/irprop_plus_step_update_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// irprop_plus_step_update_test
// self-checking bench for the irprop+ step generator
// ----------------------------------------------------------------------------
// Gradient beats stream in whole iterations under several register settings.
// A built-in step predictor tracks the per-coordinate size, sign and step and
// queues one expected result per accepted beat; results are compared field by
// field in order. A short directed table runs first, then random iterations.
// ----------------------------------------------------------------------------
module irprop_plus_step_update_test;
    import irp_pkg::*;

    localparam int LIMIT = 400000;

    typedef struct {
        logic signed [31:0] step;
        branch_t            branch;
        logic [9:0]         coord;
        logic               last;
    } step_result_t;

    typedef struct {
        logic signed [31:0] grad;
        logic signed [31:0] obj;
        logic               typed;    // expected result typed in
        logic signed [31:0] step;
        branch_t            branch;
    } stim_row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [29:0] cfg_wdata = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;
    logic        m_tlast;
    logic [1:0]  m_tuser;

    irprop_plus_step_update u_dut (.*);

    always #4 aclk = ~aclk;

    // predictor copy of the registers and the per-coordinate lines
    logic [10:0] n_coords;
    logic [29:0] size_init, size_floor, size_ceil;
    logic [15:0] grow_k;
    logic [13:0] shrink_k;
    logic [29:0] coord_size [MAX_PARAMS];
    logic [1:0]  coord_sign [MAX_PARAMS];
    logic [31:0] coord_step [MAX_PARAMS];
    logic signed [31:0] last_obj;
    logic        warmed_up, got_worse;
    logic [9:0]  coord_pos;

    step_result_t pending_steps[$];
    int          errors = 0;
    int          cycle = 0;
    bit          quiet_out = 0;
    stim_row_t   rows[$];

    always @(posedge aclk) begin
        cycle <= cycle + 1;
        if (cycle > LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("mismatch %s: got %h want %h at cycle %0d", what, got, want, cycle);
        errors++;
    endtask

    // size times factor, dropping the 14 fraction bits; keeps the full 32 bits
    function automatic logic [31:0] resize(input logic [29:0] sz, input logic [15:0] k);
        logic [45:0] p;
        p = sz * k;
        return p[45:14];
    endfunction

    // works out one coordinate's step and updates the predictor's lines
    function automatic step_result_t predict_step(input logic signed [31:0] g,
                                                  input logic signed [31:0] obj);
        step_result_t r;
        logic [10:0] cnt;
        logic [29:0] sz;
        logic [31:0] t;
        logic [1:0] gs, ps;
        logic signed [32:0] st;
        cnt = (n_coords == 0) ? 11'd1 : (n_coords > MAX_PARAMS) ? 11'(MAX_PARAMS) : n_coords;
        if (coord_pos == 0) begin
            got_worse = warmed_up && (obj > last_obj);
            last_obj = obj;
        end
        gs = (g > 0) ? SIGN_POS : (g < 0) ? SIGN_NEG : SIGN_ZERO;
        sz = warmed_up ? coord_size[coord_pos] : size_init;
        ps = warmed_up ? coord_sign[coord_pos] : SIGN_ZERO;
        if (ps != SIGN_ZERO && gs != SIGN_ZERO && ps == gs) begin
            t = resize(sz, grow_k);
            sz = (t < {2'b0, size_ceil}) ? t[29:0] : size_ceil;
            st = (gs == SIGN_POS) ? -$signed({3'b0, sz}) : $signed({3'b0, sz});
            r.branch = BR_GROW;
        end else if (ps != SIGN_ZERO && gs != SIGN_ZERO) begin
            t = resize(sz, {2'b0, shrink_k});
            sz = (t > {2'b0, size_floor}) ? t[29:0] : size_floor;
            if (got_worse) begin
                st = -$signed({coord_step[coord_pos][31], coord_step[coord_pos]});
                if (st > 33'sd2147483647) st = 33'sd2147483647;
                r.branch = BR_REVERT;
            end else begin
                st = 0;
                r.branch = BR_HOLD;
            end
            gs = SIGN_ZERO;
        end else begin
            st = (gs == SIGN_POS) ? -$signed({3'b0, sz})
               : (gs == SIGN_NEG) ? $signed({3'b0, sz}) : 33'sd0;
            r.branch = BR_KEEP;
        end
        coord_size[coord_pos] = sz;
        coord_sign[coord_pos] = gs;
        coord_step[coord_pos] = st[31:0];
        r.step = st[31:0];
        r.coord = coord_pos;
        r.last = (11'(coord_pos) + 11'd1 >= cnt);
        if (r.last) begin
            coord_pos = 0;
            warmed_up = 1;
        end else coord_pos++;
        return r;
    endfunction

    task automatic write_reg(input logic [2:0] idx, input logic [29:0] val);
        @(negedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        case (idx)
            CFG_PARAM_COUNT:   n_coords = val[10:0];
            CFG_DELTA_INITIAL: size_init = val;
            CFG_DELTA_FLOOR:   size_floor = val;
            CFG_DELTA_CEILING: size_ceil = val;
            CFG_GROW_FACTOR:   grow_k = val[15:0];
            CFG_SHRINK_FACTOR: shrink_k = val[13:0];
            default: ;
        endcase
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    // one input beat; the sender idles about 20 in 100 unless told not to
    // tvalid stays high after the beat so the next one can follow directly
    task automatic send_beat(input logic signed [31:0] g, input logic signed [31:0] obj,
                             input bit steady);
        step_result_t r;
        while (!steady && $urandom_range(99) < 20) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {obj, g};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        r = predict_step(g, obj);
        pending_steps.push_back(r);
        @(negedge aclk);
    endtask

    task automatic drain;
        s_tvalid <= 1'b0;
        while (pending_steps.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        @(negedge aclk);
    endtask

    // receiver: random stalls, sampled at the rising edge
    always @(negedge aclk)
        m_tready <= quiet_out || ($urandom_range(99) >= 20);

    always @(posedge aclk) begin
        step_result_t w;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_steps.size() == 0) begin
                report("unexpected beat", m_tdata[31:0], 32'd0);
            end else begin
                w = pending_steps.pop_front();
                if (m_tdata[31:0] !== w.step) report("step_value", m_tdata[31:0], w.step);
                if (m_tuser !== w.branch)
                    report("branch_taken", 32'(m_tuser), 32'(w.branch));
                if (m_tdata[41:32] !== w.coord)
                    report("coord_index", 32'(m_tdata[41:32]), 32'(w.coord));
                if (m_tdata[47:42] !== 6'd0) report("tdata pad", 32'(m_tdata[47:42]), 32'd0);
                if (m_tlast !== w.last) report("iteration_end", 32'(m_tlast), 32'(w.last));
            end
        end
    end

    // typed expectations checked against the predictor as the row is sent
    task automatic run_row(input stim_row_t row);
        if (row.typed) begin
            step_result_t r;
            logic [29:0] s0 [MAX_PARAMS];
            logic [1:0] g0 [MAX_PARAMS];
            logic [31:0] p0 [MAX_PARAMS];
            logic signed [31:0] lo;
            logic w0, wk;
            logic [9:0] c0;
            s0 = coord_size; g0 = coord_sign; p0 = coord_step;
            lo = last_obj; w0 = warmed_up; wk = got_worse; c0 = coord_pos;
            r = predict_step(row.grad, row.obj);
            coord_size = s0; coord_sign = g0; coord_step = p0;
            last_obj = lo; warmed_up = w0; got_worse = wk; coord_pos = c0;
            if (r.step !== row.step || r.branch !== row.branch)
                report("table row", r.step, row.step);
        end
        send_beat(row.grad, row.obj, 0);
    endtask

    function automatic logic signed [31:0] rand_grad;
        case ($urandom_range(9))
            0:       return 0;
            1:       return 32'sh8000_0000;
            2:       return 32'sh7fff_ffff;
            3, 4:    return $urandom_range(1, 1 << 26);
            5, 6:    return -$signed(32'($urandom_range(1, 1 << 26)));
            default: return $urandom;
        endcase
    endfunction

    // one iteration with a sign pattern bias so every branch shows up
    task automatic run_iteration(input logic signed [31:0] obj, input int n, input bit steady);
        for (int i = 0; i < n; i++) begin
            logic signed [31:0] g;
            g = rand_grad();
            if ($urandom_range(3) == 0 && warmed_up && coord_sign[i] != SIGN_ZERO)
                g = (coord_sign[i] == SIGN_POS) ? -$signed(32'($urandom_range(1, 255)))
                                                : 32'($urandom_range(1, 255));
            send_beat(g, obj, steady);
        end
    endtask

    initial begin
        int done;
        int n;
        logic signed [31:0] obj;
        n_coords = 1024; size_init = 1677722; size_floor = 17; size_ceil = 838860800;
        grow_k = 19661; shrink_k = 8192;
        warmed_up = 0; got_worse = 0; coord_pos = 0; last_obj = 0;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed: 4 coordinates, default factors
        write_reg(CFG_PARAM_COUNT, 30'd4);
        // first iteration: all keep with the starting size
        rows.push_back('{32'sd1000, 32'sd100, 1, -32'sd1677722, BR_KEEP});
        rows.push_back('{-32'sd1000, 32'sd100, 1, 32'sd1677722, BR_KEEP});
        rows.push_back('{32'sd0, 32'sd100, 1, 32'sd0, BR_KEEP});
        rows.push_back('{32'sh7fff_ffff, 32'sd100, 1, -32'sd1677722, BR_KEEP});
        // objective worse: grow, revert, keep, revert
        rows.push_back('{32'sd5, 32'sd200, 1, -32'sd2013286, BR_GROW});
        rows.push_back('{32'sd5, 32'sd200, 1, -32'sd1677722, BR_REVERT});
        rows.push_back('{32'sh8000_0000, 32'sd200, 0, 0, BR_KEEP});
        rows.push_back('{32'sh8000_0000, 32'sd200, 1, 32'sd1677722, BR_REVERT});
        // objective better: hold on flips; then objective worse again
        rows.push_back('{-32'sd7, 32'sh8000_0000, 1, 32'sd0, BR_HOLD});
        rows.push_back('{32'sd9, 32'sh8000_0000, 0, 0, BR_KEEP});
        rows.push_back('{32'sh7fff_ffff, 32'sh8000_0000, 0, 0, BR_KEEP});
        rows.push_back('{32'sd1, 32'sh8000_0000, 0, 0, BR_KEEP});
        rows.push_back('{32'sd3, 32'sh7fff_ffff, 0, 0, BR_KEEP});
        rows.push_back('{32'sd3, 32'sh7fff_ffff, 0, 0, BR_GROW});
        rows.push_back('{-32'sd3, 32'sh7fff_ffff, 0, 0, BR_KEEP});
        rows.push_back('{-32'sd3, 32'sh7fff_ffff, 0, 0, BR_KEEP});
        foreach (rows[i]) run_row(rows[i]);
        drain();

        // extreme sizes to force clamps
        write_reg(CFG_DELTA_CEILING, 30'h3fff_ffff);
        write_reg(CFG_GROW_FACTOR, 30'hffff);
        write_reg(CFG_SHRINK_FACTOR, 30'd0);
        write_reg(CFG_DELTA_FLOOR, 30'h3fff_ffff);
        for (int k = 0; k < 6; k++) run_iteration(32'sd100 + k, 4, 0);
        drain();
        write_reg(CFG_DELTA_FLOOR, 30'd1);
        write_reg(CFG_SHRINK_FACTOR, 30'h3fff);
        write_reg(CFG_DELTA_CEILING, 30'd1);
        write_reg(CFG_GROW_FACTOR, 30'd16384);
        for (int k = 0; k < 4; k++) run_iteration(32'sd100 - k, 4, 0);
        drain();

        // random phases; param_count only lowered so stored lines stay written
        done = 0;
        n = 4;
        obj = 0;
        for (int phase = 0; done < 1300; phase++) begin
            if (phase % 3 == 0) begin
                write_reg(CFG_DELTA_INITIAL,
                          30'($urandom_range(1, 30'h3fff_ffff) >> $urandom_range(8)) | 30'd1);
                write_reg(CFG_DELTA_FLOOR, 30'($urandom_range(1, 1 << 20)));
                write_reg(CFG_DELTA_CEILING, 30'($urandom_range(1 << 20, 30'h3fff_ffff)));
                write_reg(CFG_GROW_FACTOR, 30'($urandom_range(16384, 65535)));
                write_reg(CFG_SHRINK_FACTOR, 30'($urandom_range(0, 16383)));
            end
            if (phase == 5 && n > 1) begin
                n = (phase == 5) ? 1 : n;
                write_reg(CFG_PARAM_COUNT, 30'(n));
            end
            quiet_out = (phase % 7 == 3);
            for (int k = 0; k < 8; k++) begin
                obj = ($urandom_range(1)) ? obj + $signed(32'($urandom_range(50))) :
                      obj - $signed(32'($urandom_range(50)));
                if ($urandom_range(15) == 0) obj = $urandom;
                run_iteration(obj, n, quiet_out);
                done += n;
            end
            drain();
        end
        quiet_out = 0;

        // whole-size iteration after reset of count is not allowed (unwritten
        // lines), so the last run uses param_count 0, acting as 1, instead
        write_reg(CFG_PARAM_COUNT, 30'd0);
        run_iteration(32'sd5, 3, 0);
        drain();

        if (errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    final_check: assert property (@(posedge aclk) 1);
endmodule
